FILE: rtl/core/nearest_resize_int8_quantizer_macros.svh
// Assertion helpers for the resize/quantize block.
// Both macros sample on clk and are held off while rst_n is low.
`ifndef NEAREST_RESIZE_INT8_QUANTIZER_MACROS_SVH
`define NEAREST_RESIZE_INT8_QUANTIZER_MACROS_SVH

// Check that a condition holds at every clock edge
`define NRQ_ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("nrq invariant violated");

// Check that an antecedent implies a consequent in the same cycle
`define NRQ_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("nrq implication violated");

`endif

FILE: rtl/core/nrq_pkg.sv
`timescale 1ns / 1ps
package nrq_pkg;

    // Configuration register indexes
    localparam logic [1:0] CFG_SOURCE_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_SOURCE_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_QUANT_GAIN    = 2'd2;
    localparam logic [1:0] CFG_ZERO_OFFSET   = 2'd3;

    // Reset values of the configuration registers
    localparam logic [11:0]       RST_SOURCE_WIDTH  = 12'd320;
    localparam logic [11:0]       RST_SOURCE_HEIGHT = 12'd240;
    localparam logic [23:0]       RST_QUANT_GAIN    = 24'd65536;
    localparam logic signed [7:0] RST_ZERO_OFFSET   = -8'sd128;

    // Saturation bounds and rounding constant of the quantizer
    localparam logic signed [17:0] Q_MIN      = -18'sd128;
    localparam logic signed [17:0] Q_MAX      = 18'sd127;
    localparam logic [32:0]        ROUND_HALF = 33'd32768;

    typedef struct packed {
        logic       frame_start;
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
    } pix_in_t;

    typedef struct packed {
        logic signed [7:0] red_q;
        logic signed [7:0] green_q;
        logic signed [7:0] blue_q;
        logic              frame_last;
    } pix_out_t;

endpackage

FILE: rtl/core/nearest_resize_int8_quantizer.sv
`timescale 1ns / 1ps
// Channel   Direction  Handshake              Payload
// pix       in         pix_valid / pix_stall  nrq_pkg::pix_in_t
// res       out        res_valid / res_stall  nrq_pkg::pix_out_t
// cfg       in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One source pixel is accepted every cycle unless pix_stall is high; a selected
// pixel enters the select stage at the edge that takes it and then moves on to the
// result register when that register advances. The row/column counters advance on each accepted pixel.
// Reset clears all counters and loads the default configuration.
// A stalled result holds its register; pix_stall rises only while the select
// stage also holds a selected pixel.
module nearest_resize_int8_quantizer #(
    parameter int OUT_SIZE = 96
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              pix_valid,
    output logic              pix_stall,
    input  nrq_pkg::pix_in_t  pix,
    output logic              res_valid,
    input  logic              res_stall,
    output nrq_pkg::pix_out_t res,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [1:0]        cfg_index,
    input  logic [23:0]       cfg_data
);
    import nrq_pkg::*;

    `include "nearest_resize_int8_quantizer_macros.svh"

    localparam int DC_W  = $clog2(OUT_SIZE + 1);
    localparam int ACC_W = 12 + DC_W;
    localparam logic [ACC_W-1:0] OUT_A  = ACC_W'(OUT_SIZE);
    localparam logic [DC_W-1:0]  OUT_D  = DC_W'(OUT_SIZE);
    localparam logic [DC_W-1:0]  LAST_D = DC_W'(OUT_SIZE - 1);

    // Configuration registers
    logic [11:0]       width_reg;
    logic [11:0]       height_reg;
    logic [23:0]       gain_reg;
    logic signed [7:0] zp_reg;

    // Position counters; scl tracks src index times OUT_SIZE
    logic [11:0]      src_col_reg, src_col_next, src_col_e;
    logic [11:0]      src_row_reg, src_row_next, src_row_e;
    logic [DC_W-1:0]  dst_col_reg, dst_col_next, dst_col_e;
    logic [DC_W-1:0]  dst_row_reg, dst_row_next, dst_row_e;
    logic [ACC_W-1:0] col_acc_reg, col_acc_next, col_acc_e;
    logic [ACC_W-1:0] row_acc_reg, row_acc_next, row_acc_e;
    logic [ACC_W-1:0] col_scl_reg, col_scl_next, col_scl_e;
    logic [ACC_W-1:0] row_scl_reg, row_scl_next, row_scl_e;

    logic col_hit, row_hit, row_end, frame_end;
    logic pix_take, s1_adv, out_adv;

    // Select stage
    logic       s1_valid_reg;
    logic [7:0] s1_red_reg, s1_green_reg, s1_blue_reg;
    logic       s1_last_reg;

    logic signed [7:0] red_q, green_q, blue_q;

    // Configuration writes are always accepted
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= RST_SOURCE_WIDTH;
            height_reg <= RST_SOURCE_HEIGHT;
            gain_reg   <= RST_QUANT_GAIN;
            zp_reg     <= RST_ZERO_OFFSET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_SOURCE_WIDTH:  width_reg  <= cfg_data[11:0];
                CFG_SOURCE_HEIGHT: height_reg <= cfg_data[11:0];
                CFG_QUANT_GAIN:    gain_reg   <= cfg_data;
                CFG_ZERO_OFFSET:   zp_reg     <= $signed(cfg_data[7:0]);
                default:           width_reg  <= width_reg;
            endcase
        end
    end

    // Handshake control of the two-stage pipeline
    assign out_adv   = !res_valid || !res_stall;
    assign s1_adv    = !s1_valid_reg || out_adv;
    assign pix_stall = !s1_adv;
    assign pix_take  = pix_valid && !pix_stall;

    // Clear counters on a frame start before using them
    always_comb
    begin
        src_col_e = pix.frame_start ? '0 : src_col_reg;
        src_row_e = pix.frame_start ? '0 : src_row_reg;
        dst_col_e = pix.frame_start ? '0 : dst_col_reg;
        dst_row_e = pix.frame_start ? '0 : dst_row_reg;
        col_acc_e = pix.frame_start ? '0 : col_acc_reg;
        row_acc_e = pix.frame_start ? '0 : row_acc_reg;
        col_scl_e = pix.frame_start ? '0 : col_scl_reg;
        row_scl_e = pix.frame_start ? '0 : row_scl_reg;
    end

    // Target reached when dst*size < (src+1)*OUT_SIZE
    assign col_hit   = (dst_col_e < OUT_D) && (col_acc_e < col_scl_e + OUT_A);
    assign row_hit   = (dst_row_e < OUT_D) && (row_acc_e < row_scl_e + OUT_A);
    assign row_end   = ({1'b0, src_col_e} + 13'd1) >= {1'b0, width_reg};
    assign frame_end = ({1'b0, src_row_e} + 13'd1) >= {1'b0, height_reg};

    // Advance column and row counters
    always_comb
    begin
        src_col_next = src_col_e + 12'd1;
        col_scl_next = col_scl_e + OUT_A;
        dst_col_next = dst_col_e;
        col_acc_next = col_acc_e;
        src_row_next = src_row_e;
        row_scl_next = row_scl_e;
        dst_row_next = dst_row_e;
        row_acc_next = row_acc_e;
        if (col_hit)
        begin
            dst_col_next = dst_col_e + DC_W'(1);
            col_acc_next = col_acc_e + ACC_W'(width_reg);
        end
        if (row_end)
        begin
            src_col_next = '0;
            col_scl_next = '0;
            dst_col_next = '0;
            col_acc_next = '0;
            if (row_hit)
            begin
                dst_row_next = dst_row_e + DC_W'(1);
                row_acc_next = row_acc_e + ACC_W'(height_reg);
            end
            if (frame_end)
            begin
                src_row_next = '0;
                row_scl_next = '0;
                dst_row_next = '0;
                row_acc_next = '0;
            end
            else
            begin
                src_row_next = src_row_e + 12'd1;
                row_scl_next = row_scl_e + OUT_A;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_col_reg <= '0;
            src_row_reg <= '0;
            dst_col_reg <= '0;
            dst_row_reg <= '0;
            col_acc_reg <= '0;
            row_acc_reg <= '0;
            col_scl_reg <= '0;
            row_scl_reg <= '0;
        end
        else if (pix_take)
        begin
            src_col_reg <= src_col_next;
            src_row_reg <= src_row_next;
            dst_col_reg <= dst_col_next;
            dst_row_reg <= dst_row_next;
            col_acc_reg <= col_acc_next;
            row_acc_reg <= row_acc_next;
            col_scl_reg <= col_scl_next;
            row_scl_reg <= row_scl_next;
        end
    end

    // Load selected pixels; drop the rest
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_adv)
        begin
            s1_valid_reg <= pix_take && col_hit && row_hit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv && pix_take)
        begin
            s1_red_reg   <= pix.red_in;
            s1_green_reg <= pix.green_in;
            s1_blue_reg  <= pix.blue_in;
            s1_last_reg  <= (dst_row_e == LAST_D) && (dst_col_e == LAST_D);
        end
    end

    // Quantize the three channels
    nrq_quant u_quant_red (
        .pixel  (s1_red_reg),
        .gain   (gain_reg),
        .offset (zp_reg),
        .quant  (red_q)
    );

    nrq_quant u_quant_green (
        .pixel  (s1_green_reg),
        .gain   (gain_reg),
        .offset (zp_reg),
        .quant  (green_q)
    );

    nrq_quant u_quant_blue (
        .pixel  (s1_blue_reg),
        .gain   (gain_reg),
        .offset (zp_reg),
        .quant  (blue_q)
    );

    // Result register; hold while stalled
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid <= 1'b0;
        end
        else if (out_adv)
        begin
            res_valid <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_adv && s1_valid_reg)
        begin
            res.red_q      <= red_q;
            res.green_q    <= green_q;
            res.blue_q     <= blue_q;
            res.frame_last <= s1_last_reg;
        end
    end

    // Checks
    `NRQ_ASSERT_ALWAYS(a_dst_col_bound, dst_col_reg <= OUT_D)
    `NRQ_ASSERT_ALWAYS(a_dst_row_bound, dst_row_reg <= OUT_D)
    `NRQ_ASSERT_ALWAYS(a_col_scale, col_scl_reg == ACC_W'(src_col_reg * OUT_SIZE))
    `NRQ_ASSERT_IMPL(a_res_from_s1, $rose(res_valid), $past(s1_valid_reg))

endmodule

FILE: rtl/core/nrq_quant.sv
`timescale 1ns / 1ps
module nrq_quant (
    input  logic [7:0]        pixel,
    input  logic [23:0]       gain,
    input  logic signed [7:0] offset,
    output logic signed [7:0] quant
);
    import nrq_pkg::*;

    logic [31:0]        product;
    logic [32:0]        rounded;
    logic signed [17:0] biased;

    // Scale, round half up, add zero point
    assign product = {24'd0, pixel} * {8'd0, gain};
    assign rounded = {1'b0, product} + ROUND_HALF;
    assign biased  = $signed({1'b0, rounded[32:16]}) + 18'(offset);

    // Saturate to the int8 range
    always_comb
    begin
        if (biased < Q_MIN)
        begin
            quant = Q_MIN[7:0];
        end
        else if (biased > Q_MAX)
        begin
            quant = Q_MAX[7:0];
        end
        else
        begin
            quant = biased[7:0];
        end
    end

endmodule

FILE: sim/tb_nearest_resize_int8_quantizer.sv
`timescale 1ns / 1ps
module tb_nearest_resize_int8_quantizer;
    import nrq_pkg::*;

    localparam int OUT_SIZE   = 96;
    localparam int RAND_ITEMS = 1800;

    typedef struct packed {
        logic              reconfig;
        logic [11:0]       w;
        logic [11:0]       h;
        logic [23:0]       g;
        logic [7:0]        z;
        pix_in_t           px;
        logic              typed;
        pix_out_t          want;
    } plan_row_t;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        pix_valid = 1'b0;
    logic        pix_stall;
    pix_in_t     pix       = '0;
    logic        res_valid;
    logic        res_stall = 1'b0;
    pix_out_t    res;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [23:0] cfg_data  = '0;

    // Shadow configuration and scan position of the resizer
    logic [11:0]       width_r  = RST_SOURCE_WIDTH;
    logic [11:0]       height_r = RST_SOURCE_HEIGHT;
    logic [23:0]       gain_r   = RST_QUANT_GAIN;
    logic signed [7:0] zero_r   = RST_ZERO_OFFSET;
    logic [11:0]       sx = '0;
    logic [11:0]       sy = '0;
    logic [10:0]       dx = '0;
    logic [10:0]       dy = '0;
    logic [21:0]       x_acc = '0;
    logic [21:0]       y_acc = '0;

    pix_out_t  due[$];
    plan_row_t plan[$];
    int        errors      = 0;
    int        pixels_sent = 0;
    int        hold_left   = 0;
    bit        tx_idle_on  = 1'b1;
    bit        rx_idle_on  = 1'b1;
    pix_out_t  oldest;

    nearest_resize_int8_quantizer #(
        .OUT_SIZE (OUT_SIZE)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix_valid (pix_valid),
        .pix_stall (pix_stall),
        .pix       (pix),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // Scale one channel by the gain, round half up, add zero point, clamp to int8
    function automatic logic signed [7:0] to_int8(input logic [7:0] p);
        longint unsigned prod;
        int              r;
        prod = longint'(p) * longint'(gain_r);
        r = int'((prod + 64'd32768) >> 16) + int'(zero_r);
        if (r < -128)
            r = -128;
        else if (r > 127)
            r = 127;
        return r[7:0];
    endfunction

    // Advance the scan by one source pixel and report the selected output, if any
    function automatic void predict_pixel(input pix_in_t px, output bit fires,
                                          output pix_out_t q);
        bit col_hit;
        bit row_hit;
        if (px.frame_start) begin
            sx    = '0;
            sy    = '0;
            dx    = '0;
            dy    = '0;
            x_acc = '0;
            y_acc = '0;
        end
        col_hit = (dx < OUT_SIZE) && (x_acc / OUT_SIZE <= sx);
        row_hit = (dy < OUT_SIZE) && (y_acc / OUT_SIZE <= sy);
        fires   = col_hit && row_hit;
        q.red_q      = to_int8(px.red_in);
        q.green_q    = to_int8(px.green_in);
        q.blue_q     = to_int8(px.blue_in);
        q.frame_last = (dy == OUT_SIZE - 1) && (dx == OUT_SIZE - 1);
        if (col_hit) begin
            dx    = dx + 11'd1;
            x_acc = x_acc + width_r;
        end
        // Wrap column at end of row, row at end of frame
        if (int'(sx) + 1 >= int'(width_r)) begin
            sx    = '0;
            dx    = '0;
            x_acc = '0;
            if (row_hit) begin
                dy    = dy + 11'd1;
                y_acc = y_acc + height_r;
            end
            if (int'(sy) + 1 >= int'(height_r)) begin
                sy    = '0;
                dy    = '0;
                y_acc = '0;
            end
            else
                sy = sy + 12'd1;
        end
        else
            sx = sx + 12'd1;
    endfunction

    function automatic logic [7:0] rand_chan();
        case ($urandom_range(0, 7))
            0:       return 8'd0;
            1:       return 8'd255;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic pix_in_t rand_pixel(input bit fs);
        pix_in_t px;
        px.frame_start = fs;
        px.red_in      = rand_chan();
        px.green_in    = rand_chan();
        px.blue_in     = rand_chan();
        return px;
    endfunction

    function automatic logic [23:0] rand_gain();
        case ($urandom_range(0, 5))
            0:       return 24'd0;
            1:       return 24'hFFFFFF;
            2:       return 24'd65536;
            3:       return 24'($urandom_range(0, 131072));
            default: return 24'($urandom);
        endcase
    endfunction

    function automatic logic [7:0] rand_zero();
        case ($urandom_range(0, 4))
            0:       return 8'h80;
            1:       return 8'h7F;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic plan_cfg(input logic [11:0] w, input logic [11:0] h,
                            input logic [23:0] g, input logic [7:0] z);
        plan_row_t row;
        row          = '0;
        row.reconfig = 1'b1;
        row.w        = w;
        row.h        = h;
        row.g        = g;
        row.z        = z;
        plan.push_back(row);
    endtask

    task automatic plan_pix(input bit fs, input int r, input int g, input int b,
                            input bit typed, input int rq, input int gq, input int bq,
                            input bit last);
        plan_row_t row;
        row                   = '0;
        row.px.frame_start    = fs;
        row.px.red_in         = r[7:0];
        row.px.green_in       = g[7:0];
        row.px.blue_in        = b[7:0];
        row.typed             = typed;
        row.want.red_q        = rq[7:0];
        row.want.green_q      = gq[7:0];
        row.want.blue_q       = bq[7:0];
        row.want.frame_last   = last;
        plan.push_back(row);
    endtask

    // Hold off the pixel stream until every selected pixel has drained
    task automatic settle();
        pix_valid <= 1'b0;
        while (due.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [23:0] val);
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            CFG_SOURCE_WIDTH:  width_r  = val[11:0];
            CFG_SOURCE_HEIGHT: height_r = val[11:0];
            CFG_QUANT_GAIN:    gain_r   = val;
            CFG_ZERO_OFFSET:   zero_r   = val[7:0];
        endcase
    endtask

    // Write all four registers back to back; unused upper data bits carry junk
    task automatic load_regs(input logic [11:0] w, input logic [11:0] h,
                             input logic [23:0] g, input logic [7:0] z);
        cfg_valid <= 1'b1;
        write_reg(CFG_SOURCE_WIDTH, {12'($urandom), w});
        write_reg(CFG_SOURCE_HEIGHT, {12'($urandom), h});
        write_reg(CFG_QUANT_GAIN, g);
        write_reg(CFG_ZERO_OFFSET, {16'($urandom), z});
        cfg_valid <= 1'b0;
    endtask

    // Offer one pixel after a random gap and record its expected output on transfer
    task automatic push_pixel(input pix_in_t px, input bit typed, input pix_out_t want);
        int       gap;
        bit       fires;
        pix_out_t q;
        gap = tx_idle_on ? $urandom_range(0, 15) : 0;
        if (gap > 0) begin
            pix_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pix_valid <= 1'b1;
        pix       <= px;
        @(posedge clk);
        while (pix_stall)
            @(posedge clk);
        pixels_sent++;
        predict_pixel(px, fires, q);
        if (typed)
            due.push_back(want);
        else if (fires)
            due.push_back(q);
    endtask

    task automatic random_phase(input bit force_end);
        int          mode;
        int          n;
        bit          fs;
        logic [11:0] w;
        logic [11:0] h;
        logic [23:0] g;
        logic [7:0]  z;
        mode = force_end ? 0 : $urandom_range(0, 9);
        g    = rand_gain();
        z    = rand_zero();
        settle();
        tx_idle_on = ($urandom_range(0, 3) != 0);
        rx_idle_on <= ($urandom_range(0, 3) != 0);
        if (mode == 0) begin
            // Walk one-pixel rows down to the last output row, then widen the
            // row so the final output pixel of the frame gets selected
            h = 12'(96 + $urandom_range(0, 2));
            load_regs(12'd1, h, g, z);
            push_pixel(rand_pixel(1'b1), 1'b0, '0);
            while (dy < OUT_SIZE - 1)
                push_pixel(rand_pixel(1'b0), 1'b0, '0);
            settle();
            load_regs(12'(96 + $urandom_range(0, 20)), h, g, z);
            do
                push_pixel(rand_pixel(1'b0), 1'b0, '0);
            while (sx != 0 || sy != 0);
        end
        else begin
            if (mode <= 4) begin
                w = 12'($urandom_range(0, 12));
                h = 12'($urandom_range(0, 12));
                n = $urandom_range(20, 150);
            end
            else if (mode <= 7) begin
                w = 12'($urandom_range(96, 200));
                h = 12'($urandom_range(1, 8));
                n = $urandom_range(100, 400);
            end
            else begin
                w = 12'($urandom_range(97, 4095));
                h = 12'($urandom_range(96, 4095));
                n = $urandom_range(20, 120);
            end
            load_regs(w, h, g, z);
            // Mostly one frame start up front, with stray restarts as noise
            for (int i = 0; i < n; i++) begin
                fs = (i == 0) ? ($urandom_range(0, 4) != 0) : ($urandom_range(0, 39) == 0);
                push_pixel(rand_pixel(fs), 1'b0, '0);
            end
        end
    endtask

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, got %0d",
                     $time, name, $signed(want), $signed(got));
        end
    endtask

    // Check each result transfer and draw the stall that follows it
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            res_stall <= 1'b0;
            hold_left = 0;
        end
        else begin
            if (res_valid && !res_stall) begin
                if (due.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result, expected none, got %h", $time, res);
                end
                else begin
                    oldest = due.pop_front();
                    check_field("red_q", oldest.red_q, res.red_q);
                    check_field("green_q", oldest.green_q, res.green_q);
                    check_field("blue_q", oldest.blue_q, res.blue_q);
                    check_field("frame_last", {7'd0, oldest.frame_last}, {7'd0, res.frame_last});
                end
                hold_left = rx_idle_on ? $urandom_range(0, 15) : 0;
            end
            if (hold_left > 0) begin
                res_stall <= 1'b1;
                hold_left--;
            end
            else
                res_stall <= 1'b0;
        end
    end

    initial begin
        // Defaults after reset: 320x240, unity gain, zero point -128
        plan_pix(1, 0, 255, 128, 1, -128, 127, 0, 0);
        plan_pix(0, 17, 34, 51, 0, 0, 0, 0, 0);
        plan_pix(0, 68, 85, 102, 0, 0, 0, 0, 0);
        plan_pix(0, 255, 0, 1, 0, 0, 0, 0, 0);
        plan_pix(1, 255, 255, 255, 1, 127, 127, 127, 0);
        // Single-pixel frames, full-scale gain saturates every nonzero channel
        plan_cfg(12'd1, 12'd1, 24'hFFFFFF, 8'h80);
        plan_pix(1, 0, 1, 255, 1, -128, 127, 127, 0);
        plan_pix(0, 128, 0, 77, 1, 127, -128, 127, 0);
        // Size zero with zero gain leaves only the zero point
        plan_cfg(12'd0, 12'd0, 24'd0, 8'h7F);
        plan_pix(0, 200, 100, 50, 1, 127, 127, 127, 0);
        plan_pix(1, 0, 0, 0, 1, 127, 127, 127, 0);
        // Largest source, half gain shows rounding of exact halves upward
        plan_cfg(12'd4095, 12'd4095, 24'd32768, 8'h00);
        plan_pix(1, 1, 3, 255, 1, 1, 2, 127, 0);
        plan_pix(0, 254, 2, 0, 0, 0, 0, 0, 0);
        plan_pix(0, 0, 255, 9, 0, 0, 0, 0, 0);
        plan_pix(0, 99, 100, 101, 0, 0, 0, 0, 0);
        // Source equal to output size: every pixel is selected
        plan_cfg(12'd96, 12'd96, 24'd65536, 8'hFF);
        plan_pix(1, 0, 128, 255, 1, -1, 127, 127, 0);
        plan_pix(0, 1, 2, 3, 0, 0, 0, 0, 0);
        plan_pix(0, 250, 251, 252, 0, 0, 0, 0, 0);
        plan_pix(0, 127, 128, 129, 0, 0, 0, 0, 0);
        plan_pix(0, 0, 0, 255, 0, 0, 0, 0, 0);

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Walk the directed table
        foreach (plan[i]) begin
            if (plan[i].reconfig) begin
                settle();
                load_regs(plan[i].w, plan[i].h, plan[i].g, plan[i].z);
            end
            else
                push_pixel(plan[i].px, plan[i].typed, plan[i].want);
        end

        // Random frames until the pixel budget is spent
        random_phase(1'b1);
        while (pixels_sent < plan.size() + RAND_ITEMS)
            random_phase(1'b0);

        settle();
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // Watchdog
    initial begin
        #4_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
